// ===== rtl/core/line_pattern_matcher_assert.svh =====
// Assertion macros shared by the line pattern matcher modules.
`ifndef LINE_PATTERN_MATCHER_ASSERT_SVH
`define LINE_PATTERN_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lpm_pkg.sv =====
// Shared types, constants and helpers for the line pattern matcher.
`timescale 1ns / 1ps
`default_nettype none

package lpm_pkg;

  // Parameter defaults
  localparam int PATTERN_MAX_DEF = 16;
  localparam int LINE_CAP_DEF    = 2048;

  // Field and register widths
  localparam int BYTE_W      = 8;
  localparam int MOD_W       = 2;
  localparam int LEN_OUT_W   = 11;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int MODS_W      = 32;
  localparam int PLEN_W      = 5;
  localparam int REG_ELEMS   = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODS       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH     = 8'd3;

  // Modifier codes; code 3 acts as none
  localparam logic [MOD_W-1:0] MOD_NONE     = 2'd0;
  localparam logic [MOD_W-1:0] MOD_STAR     = 2'd1;
  localparam logic [MOD_W-1:0] MOD_QUESTION = 2'd2;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;
  localparam logic [BYTE_W-1:0] CHAR_DIG_LO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_DIG_HI  = 8'd57;
  localparam logic [BYTE_W-1:0] CHAR_UPR_LO  = 8'd65;
  localparam logic [BYTE_W-1:0] CHAR_UPR_HI  = 8'd90;
  localparam logic [BYTE_W-1:0] CHAR_LWR_LO  = 8'd97;
  localparam logic [BYTE_W-1:0] CHAR_LWR_HI  = 8'd122;

  // Per-beat control handed to every position cell
  typedef struct packed {
    logic flush;  // new file: treat held positions as empty this beat
    logic load;   // take the stepped position set
    logic clear;  // return to the start position only
  } cell_ctrl_t;

  // One result beat
  typedef struct packed {
    logic                 ended_full;
    logic [LEN_OUT_W-1:0] line_length;
    logic                 line_matched;
  } out_beat_t;

  function automatic logic is_alnum(input logic [BYTE_W-1:0] b);
    is_alnum = (b >= CHAR_DIG_LO && b <= CHAR_DIG_HI) ||
               (b >= CHAR_UPR_LO && b <= CHAR_UPR_HI) ||
               (b >= CHAR_LWR_LO && b <= CHAR_LWR_HI);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lpm_cell.sv =====
// One NFA position cell: holds the active bit of its position and steps it.
`timescale 1ns / 1ps
`default_nettype none

module lpm_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lpm_pkg::cell_ctrl_t        ctrl,
  input  wire logic [lpm_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       byte_alnum,
  input  wire logic [lpm_pkg::BYTE_W-1:0] elem_char,
  input  wire logic [lpm_pkg::MOD_W-1:0]  elem_mod,
  input  wire logic                       elem_en,
  input  wire logic                       s_skip_in,
  input  wire logic                       adv_in,
  input  wire logic                       c_skip_in,
  output logic                            s_skip_out,
  output logic                            adv_out,
  output logic                            c_skip_out,
  output logic                            pos_hit
);
  import lpm_pkg::*;

  logic act_r;
  logic act_nxt;
  logic s_pos;
  logic c_pos;
  logic opt;
  logic star;
  logic hit;

  // Decode the element
  assign star = (elem_mod == MOD_STAR);
  assign opt  = (elem_mod == MOD_STAR) || (elem_mod == MOD_QUESTION);

  // Position set before the byte, with optional elements skipped
  assign s_pos      = (act_r & ~ctrl.flush) | s_skip_in;
  assign s_skip_out = s_pos & opt & elem_en;

  // Element consumes the byte: star stays, others advance
  assign hit     = s_pos & elem_en & byte_alnum &
                   ((elem_char == CHAR_DOT) || (elem_char == data_byte));
  assign adv_out = hit & ~star;

  // Position set after the byte, with optional elements skipped
  assign c_pos      = adv_in | (hit & star) | c_skip_in;
  assign c_skip_out = c_pos & opt & elem_en;

  assign pos_hit = s_pos | c_pos;

  // Advance, clear or hold the active bit
  always_comb begin
    priority if (ctrl.load) begin
      act_nxt = c_pos;
    end else if (ctrl.clear) begin
      act_nxt = 1'b0;
    end else begin
      act_nxt = act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lpm_out_buf.sv =====
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps
`default_nettype none

module lpm_out_buf
  `include "line_pattern_matcher_assert.svh"
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lpm_pkg::out_beat_t push_data,
  output logic                    has_room,
  output logic                    head_valid,
  output lpm_pkg::out_beat_t      head_data,
  input  wire logic               head_ready
);
  import lpm_pkg::*;

  logic      head_v_r;
  logic      head_v_nxt;
  logic      skid_v_r;
  logic      skid_v_nxt;
  out_beat_t head_r;
  out_beat_t head_nxt;
  out_beat_t skid_r;
  out_beat_t skid_nxt;
  logic      pop;

  assign pop        = head_v_r & head_ready;
  assign has_room   = ~skid_v_r;
  assign head_valid = head_v_r;
  assign head_data  = head_r;

  // Refill the head from the skid entry first, then from the pushed beat
  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        head_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        head_v_nxt = push;
        head_nxt   = push_data;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_v_nxt = 1'b1;
        head_nxt   = push_data;
      end else begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  `LPM_ASSERT_IMP(a_skid_behind_head, skid_v_r, head_v_r,
                  "skid entry held with an empty head")
  `LPM_ASSERT_IMP(a_no_push_when_full, push, !skid_v_r,
                  "result pushed into a full buffer")

endmodule

`default_nettype wire

// ===== rtl/core/line_pattern_matcher.sv =====
// Line pattern matcher: cuts a byte stream into lines and flags pattern hits.
// Throughput: one byte beat per cycle, back to back, through one pass of the
//   position cell chain; input stalls only while both result entries are full.
// Results: a line's result is registered in the result buffer and reaches out_* behind any results still held there.
// Reset (synchronous, rst_n low): pattern registers zero, start position only,
//   line count and match cleared, skip off, result buffer empty.
`timescale 1ns / 1ps
`default_nettype none

module line_pattern_matcher #(
  parameter int PATTERN_MAX = lpm_pkg::PATTERN_MAX_DEF,
  parameter int LINE_CAP    = lpm_pkg::LINE_CAP_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // data_byte [7:0]
  input  wire logic [lpm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // new_file [0]
  input  wire logic                            in_tuser,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // line_length [10:0], zero [15:11]
  output logic [lpm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // line_matched [0], ended_full [1]
  output logic [1:0]                           out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lpm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpm_pkg::*;

  `include "line_pattern_matcher_assert.svh"

  localparam int CNT_W = $clog2(LINE_CAP);
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam logic [CNT_W-1:0] LINE_FULL = CNT_W'(LINE_CAP - 1);
  localparam logic [5:0]       PMAX6     = 6'(PATTERN_MAX);

  // Pattern registers
  logic [CFG_DATA_W-1:0] chars_lo_r;
  logic [CFG_DATA_W-1:0] chars_hi_r;
  logic [MODS_W-1:0]     mods_r;
  logic [PLEN_W-1:0]     plen_r;

  // Line state
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             match_r;
  logic             match_nxt;
  logic             skip_r;
  logic             skip_nxt;

  logic [BYTE_W-1:0] data_byte;
  logic              new_file;
  logic              in_beat;
  logic              byte_alnum;
  logic [CNT_W-1:0]  cnt_eff;
  logic              match_eff;
  logic              skip_eff;
  logic              line_end;
  logic              res_push;
  logic [5:0]        plen6;
  logic [5:0]        eff_len6;
  logic [LEN_W-1:0]  eff_len;
  logic [CNT_W+LEN_OUT_W-1:0] cnt_ext;
  cell_ctrl_t        ctrl;
  out_beat_t         res;
  out_beat_t         head;
  logic              buf_room;

  // Chain signals between cells
  logic [PATTERN_MAX+1:0] s_chain;
  logic [PATTERN_MAX+1:0] adv_chain;
  logic [PATTERN_MAX+1:0] c_chain;
  logic [PATTERN_MAX:0]   pos_hit;

  assign data_byte  = in_tdata[BYTE_W-1:0];
  assign new_file   = in_tuser;
  assign in_tready  = buf_room;
  assign in_beat    = in_tvalid & in_tready;
  assign byte_alnum = is_alnum(data_byte);

  // Clamp pattern length to PATTERN_MAX elements
  assign plen6    = {1'b0, plen_r};
  assign eff_len6 = (plen6 > PMAX6) ? PMAX6 : plen6;
  assign eff_len  = eff_len6[LEN_W-1:0];

  // Config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_lo_r <= '0;
      chars_hi_r <= '0;
      mods_r     <= '0;
      plen_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHARS_LOW:  chars_lo_r <= cfg_data;
        CFG_CHARS_HIGH: chars_hi_r <= cfg_data;
        CFG_MODS:       mods_r     <= cfg_data[MODS_W-1:0];
        CFG_LENGTH:     plen_r     <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Line state as seen by this beat: a new file wipes it first
  assign cnt_eff   = new_file ? '0 : cnt_r;
  assign match_eff = new_file ? 1'b0 : match_r;
  assign skip_eff  = skip_r & ~new_file;
  assign line_end  = (data_byte == CHAR_NEWLINE) || (cnt_eff >= LINE_FULL);

  // Decide this beat's action
  always_comb begin
    cnt_nxt    = cnt_r;
    match_nxt  = match_r;
    skip_nxt   = skip_r;
    res_push   = 1'b0;
    ctrl.flush = in_beat & new_file;
    ctrl.load  = 1'b0;
    ctrl.clear = in_beat & new_file;
    if (in_beat) begin
      cnt_nxt   = cnt_eff;
      match_nxt = match_eff;
      skip_nxt  = skip_eff;
      priority if (skip_eff) begin
        // drop the byte
      end else if (data_byte[BYTE_W-1]) begin
        skip_nxt   = 1'b1;
        cnt_nxt    = '0;
        match_nxt  = 1'b0;
        ctrl.clear = 1'b1;
      end else if (line_end) begin
        res_push   = 1'b1;
        cnt_nxt    = '0;
        match_nxt  = 1'b0;
        ctrl.clear = 1'b1;
      end else begin
        cnt_nxt = cnt_eff + 1'b1;
        priority if (eff_len == '0) begin
          match_nxt  = 1'b1;
          ctrl.clear = 1'b1;
        end else if (!byte_alnum) begin
          ctrl.clear = 1'b1;
        end else begin
          ctrl.load = 1'b1;
          match_nxt = match_eff | pos_hit[eff_len];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      match_r <= 1'b0;
      skip_r  <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      match_r <= match_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Seed the chain: start position always active
  assign s_chain[0]   = 1'b1;
  assign adv_chain[0] = 1'b0;
  assign c_chain[0]   = 1'b0;

  // One cell per position; the last holds the accept position only
  for (genvar k = 0; k <= PATTERN_MAX; k++) begin : g_cell
    logic [BYTE_W-1:0] el_char;
    logic [MOD_W-1:0]  el_mod;
    logic              el_en;

    if (k < REG_ELEMS / 2) begin : g_lo
      assign el_char = chars_lo_r[BYTE_W*k +: BYTE_W];
    end else if (k < REG_ELEMS) begin : g_hi
      assign el_char = chars_hi_r[BYTE_W*(k-REG_ELEMS/2) +: BYTE_W];
    end else begin : g_none
      assign el_char = '0;
    end

    if (k < REG_ELEMS) begin : g_mod
      assign el_mod = mods_r[MOD_W*k +: MOD_W];
    end else begin : g_nomod
      assign el_mod = MOD_NONE;
    end

    assign el_en = (6'(k) < eff_len6);

    lpm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .data_byte  (data_byte),
      .byte_alnum (byte_alnum),
      .elem_char  (el_char),
      .elem_mod   (el_mod),
      .elem_en    (el_en),
      .s_skip_in  (s_chain[k]),
      .adv_in     (adv_chain[k]),
      .c_skip_in  (c_chain[k]),
      .s_skip_out (s_chain[k+1]),
      .adv_out    (adv_chain[k+1]),
      .c_skip_out (c_chain[k+1]),
      .pos_hit    (pos_hit[k])
    );
  end

  // Build the result beat
  assign cnt_ext          = {{LEN_OUT_W{1'b0}}, cnt_eff};
  assign res.line_matched = match_eff;
  assign res.line_length  = cnt_ext[LEN_OUT_W-1:0];
  assign res.ended_full   = (data_byte != CHAR_NEWLINE);

  lpm_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_push),
    .push_data  (res),
    .has_room   (buf_room),
    .head_valid (out_tvalid),
    .head_data  (head),
    .head_ready (out_tready)
  );

  assign out_tdata = {{(OUT_TDATA_W-LEN_OUT_W){1'b0}}, head.line_length};
  assign out_tuser = {head.ended_full, head.line_matched};

  `LPM_ASSERT_IMP(a_skip_silent, in_beat && skip_r && !new_file, !res_push,
                  "result produced while skipping the rest of a file")
  `LPM_ASSERT_NXT(a_count_clears, res_push, cnt_r == '0,
                  "line count not cleared after a line end")
  `LPM_ASSERT_IMP(a_count_bounded, 1'b1, cnt_r <= LINE_FULL,
                  "line count beyond line capacity")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for line_pattern_matcher: random files, NFA predictor, scoreboard.
`timescale 1ns / 1ps

import lpm_pkg::*;

// Tracks the line and NFA state of the matcher and holds the line results still owed.
class line_scoreboard;
  localparam int LINE_LIMIT = LINE_CAP_DEF - 1;
  localparam logic [MOD_W-1:0] MOD_RESERVED = 2'd3;

  logic [CFG_DATA_W-1:0] chars_lo;
  logic [CFG_DATA_W-1:0] chars_hi;
  logic [MODS_W-1:0]     mods;
  logic [PLEN_W-1:0]     plen;
  logic [17:0]           live_set;
  int unsigned           chars_in_line;
  bit                    line_hit;
  bit                    skipping;
  out_beat_t             owed_lines[$];
  int                    errors;

  function new();
    chars_lo = '0;
    chars_hi = '0;
    mods     = '0;
    plen     = '0;
    skipping = 0;
    errors   = 0;
    restart_line();
  endfunction

  function void restart_line();
    live_set      = 18'd1;
    chars_in_line = 0;
    line_hit      = 0;
  endfunction

  function void take_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_CHARS_LOW:  chars_lo = val;
      CFG_CHARS_HIGH: chars_hi = val;
      CFG_MODS:       mods = val[MODS_W-1:0];
      CFG_LENGTH:     plen = val[PLEN_W-1:0];
      default: ;
    endcase
  endfunction

  function bit word_char(logic [BYTE_W-1:0] b);
    return b inside {[CHAR_DIG_LO:CHAR_DIG_HI], [CHAR_UPR_LO:CHAR_UPR_HI],
                     [CHAR_LWR_LO:CHAR_LWR_HI]};
  endfunction

  function logic [BYTE_W-1:0] elem_byte(int k);
    return (k < 8) ? chars_lo[8*k +: 8] : chars_hi[8*(k-8) +: 8];
  endfunction

  function logic [MOD_W-1:0] elem_kind(int k);
    logic [MOD_W-1:0] m;
    m = mods[2*k +: 2];
    return (m == MOD_RESERVED) ? MOD_NONE : m;
  endfunction

  // Let every optional element be skipped: carry active positions forward.
  function logic [17:0] spread(logic [17:0] s, int n);
    for (int k = 0; k < n; k++) begin
      if (s[k] && elem_kind(k) != MOD_NONE) s[k+1] = 1'b1;
    end
    return s;
  endfunction

  // Advance the line state by one accepted byte beat.
  function void note_byte(logic [BYTE_W-1:0] b, logic starts_file);
    int          eff;
    logic [17:0] accept;
    logic [17:0] s;
    logic [17:0] nxt;
    logic [BYTE_W-1:0] c;
    out_beat_t   e;
    eff = (plen > REG_ELEMS) ? REG_ELEMS : int'(plen);
    accept = 18'd1 << eff;
    if (starts_file) begin
      restart_line();
      skipping = 0;
    end
    if (skipping) return;
    // High byte: drop the partial line and ignore the rest of the file
    if (b[7]) begin
      skipping = 1;
      restart_line();
      return;
    end
    if (b == CHAR_NEWLINE || chars_in_line >= LINE_LIMIT) begin
      e.line_matched = line_hit;
      e.line_length  = chars_in_line[LEN_OUT_W-1:0];
      e.ended_full   = (b != CHAR_NEWLINE);
      owed_lines.push_back(e);
      restart_line();
      return;
    end
    chars_in_line++;
    if (eff == 0) begin
      line_hit = 1;
      live_set = 18'd1;
      return;
    end
    if (!word_char(b)) begin
      live_set = 18'd1;
      return;
    end
    s = spread(live_set | 18'd1, eff);
    if (|(s & accept)) line_hit = 1;
    nxt = '0;
    for (int k = 0; k < eff; k++) begin
      c = elem_byte(k);
      if (s[k] && (c == CHAR_DOT || c == b)) begin
        if (elem_kind(k) == MOD_STAR) nxt[k] = 1'b1;
        else nxt[k+1] = 1'b1;
      end
    end
    nxt = spread(nxt, eff);
    if (|(nxt & accept)) line_hit = 1;
    live_set = nxt;
  endfunction

  function int pending();
    return owed_lines.size();
  endfunction

  // Compare one result beat with the oldest owed line.
  function void check_result(logic matched, logic [LEN_OUT_W-1:0] len, logic full);
    out_beat_t e;
    if (owed_lines.size() == 0) begin
      $error("result beat with no line owed: matched %0d length %0d full %0d",
             matched, len, full);
      errors++;
      return;
    end
    e = owed_lines.pop_front();
    if (matched !== e.line_matched) begin
      $error("line_matched: expected %0d, got %0d", e.line_matched, matched);
      errors++;
    end
    if (len !== e.line_length) begin
      $error("line_length: expected %0d, got %0d", e.line_length, len);
      errors++;
    end
    if (full !== e.ended_full) begin
      $error("ended_full: expected %0d, got %0d", e.ended_full, full);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  PHASE_BYTES  = 226;
  localparam int  SETTLE_GAP   = 4;
  localparam int  DRAIN_LIMIT  = 50000;
  localparam real RUN_LIMIT_NS = 5_000_000.0;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  line_scoreboard sb = new();

  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  int hold_ask     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int bytes_sent   = 0;
  bit file_start_due = 0;

  logic [BYTE_W-1:0] pat_char [REG_ELEMS];
  logic [MOD_W-1:0]  pat_mod  [REG_ELEMS];
  int                pat_len;

  line_pattern_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // Result side: long hold-off on request, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen  <= hold_ask;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser[0], out_tdata[LEN_OUT_W-1:0], out_tuser[1]);
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] any_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return BYTE_W'(CHAR_DIG_LO + r);
    if (r < 36) return BYTE_W'(CHAR_UPR_LO + (r - 10));
    return BYTE_W'(CHAR_LWR_LO + (r - 36));
  endfunction

  function automatic logic [BYTE_W-1:0] narrow_alnum();
    case ($urandom_range(4))
      0: return CHAR_LWR_LO;
      1: return BYTE_W'(CHAR_LWR_LO + 1);
      2: return BYTE_W'(CHAR_LWR_LO + 2);
      3: return CHAR_DIG_LO;
      default: return CHAR_UPR_HI;
    endcase
  endfunction

  // Printable or control ASCII that is neither alphanumeric nor a newline.
  function automatic logic [BYTE_W-1:0] other_ascii();
    logic [BYTE_W-1:0] c;
    do c = BYTE_W'($urandom_range(127)); while (sb.word_char(c) || c == CHAR_NEWLINE);
    return c;
  endfunction

  // Offer one byte beat and hold it until accepted; leaves valid high.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counts);
    logic nf;
    nf = file_start_due;
    file_start_due = 0;
    // idle cycle by cycle at the sender's idle rate
    while (tx_gap_pct > 0 && $urandom_range(99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= nf;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, nf);
    if (counts) bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1);
  endtask

  // Write one register; valid stays high for a following write.
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.take_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_pattern(input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                             input logic [CFG_DATA_W-1:0] md, input logic [CFG_DATA_W-1:0] ln);
    program_reg(CFG_CHARS_LOW, lo);
    program_reg(CFG_CHARS_HIGH, hi);
    program_reg(CFG_MODS, md);
    program_reg(CFG_LENGTH, ln);
    cfg_valid <= 1'b0;
  endtask

  // Pause the sender until every owed line has come back, then let the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic random_pattern(input bit full_len);
    int r;
    for (int k = 0; k < REG_ELEMS; k++) begin
      r = $urandom_range(9);
      if (r < 6) pat_char[k] = narrow_alnum();
      else if (r < 8) pat_char[k] = CHAR_DOT;
      else pat_char[k] = BYTE_W'($urandom_range(255));
      pat_mod[k] = MOD_W'($urandom_range(3));
    end
    r = $urandom_range(19);
    if (r == 0) pat_len = 0;
    else if (r == 1) pat_len = REG_ELEMS;
    else if (r == 2) pat_len = $urandom_range(REG_ELEMS + 1, 31);
    else pat_len = $urandom_range(1, 5);
    if (full_len) pat_len = REG_ELEMS;
  endtask

  task automatic load_pattern();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] md;
    lo = '0;
    hi = '0;
    md = '0;
    for (int k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat_char[k];
      hi[8*k +: 8] = pat_char[k+8];
    end
    for (int k = 0; k < REG_ELEMS; k++) md[2*k +: 2] = pat_mod[k];
    set_pattern(lo, hi, md, CFG_DATA_W'(pat_len));
  endtask

  // Emit a string built from the current pattern's elements, with random repeat counts.
  task automatic send_pattern_word();
    int eff;
    int n;
    eff = (pat_len > REG_ELEMS) ? REG_ELEMS : pat_len;
    for (int k = 0; k < eff; k++) begin
      if (pat_mod[k] == MOD_STAR) n = $urandom_range(3);
      else if (pat_mod[k] == MOD_QUESTION) n = $urandom_range(1);
      else n = 1;
      repeat (n) send_byte((pat_char[k] == CHAR_DOT) ? any_alnum() : pat_char[k], 1);
    end
  endtask

  // One line of mixed words, noise and punctuation; now and then a broken file.
  task automatic send_random_line();
    int r;
    if ($urandom_range(49) == 0) file_start_due = 1;
    repeat ($urandom_range(4)) begin
      r = $urandom_range(9);
      if (r < 4) send_pattern_word();
      else if (r < 7) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(1) != 0) ? narrow_alnum() : any_alnum(), 1);
      end else if (r < 9) send_byte(other_ascii(), 1);
      else send_byte(($urandom_range(1) != 0) ? other_ascii() : any_alnum(), 1);
    end
    r = $urandom_range(99);
    if (r < 4) begin
      // high byte: rest of the file is ignored until the next file starts
      send_byte(BYTE_W'($urandom_range(128, 255)), 1);
      repeat ($urandom_range(3)) send_byte(BYTE_W'($urandom_range(255)), 0);
      file_start_due = 1;
    end else if (r < 7) begin
      // leave the line unfinished; the next file drops it
      file_start_due = 1;
    end else begin
      send_byte(CHAR_NEWLINE, 1);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty pattern: any non-empty line matches, control bytes count as characters
    set_pattern('0, '0, '0, '0);
    send_byte(CHAR_NEWLINE, 1);
    send_byte(8'h00, 1);
    send_byte(CHAR_NEWLINE, 1);
    send_byte(8'h7F, 1);
    send_byte(CHAR_NEWLINE, 1);
    settle();

    // "a", optional dot, "b" starred: runs, skipped files, dropped partial lines
    set_pattern(64'h0000_0000_0062_2E61, '0, 64'h18, 64'd3);
    send_text("xa1\n");
    send_text("ab");
    send_byte(8'hFF, 1);
    send_byte(CHAR_LWR_LO, 0);
    file_start_due = 1;
    send_text("b\n");
    send_text("ba");
    file_start_due = 1;
    send_text("Za\n");
    settle();

    // Oversized length, all-ones high registers: reserved modifiers, elements past "ab" never match
    set_pattern(64'hFFFF_FFFF_FFFF_6261, '1, 64'hFFFF_FFFF, 64'd31);
    send_text("ab\n");
    settle();

    // Every element optional: a single alphanumeric matches
    set_pattern(64'h6261, '0, 64'h9, 64'd2);
    send_text("-\n");
    send_text("c\n");
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph / 2)
        0: begin tx_gap_pct = 14; rx_stall_pct = 52; end
        1: begin tx_gap_pct = 52; rx_stall_pct = 14; end
        default: begin tx_gap_pct = 0; rx_stall_pct = 0; end
      endcase
      random_pattern(ph == 3);
      load_pattern();
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_random_line();

      // Stall the result side and keep pushing short lines until input backs up
      if (ph == 2) begin
        settle();
        tx_gap_pct = 0;
        hold_ask++;
        repeat (60) send_text("k\n");
      end
    end

    in_tvalid <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && sb.pending() != 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d line results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
